// ===== hdl/ccb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types, register indexes and mode codes of the color key blitter.
// ----------------------------------------------------------------------------
package ccb_pkg;

    // signed width that holds every coordinate sum and difference
    localparam int XW = 19;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COLOR_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic signed [XW-1:0] coord_t;

    localparam cfg_index_t REG_DEST_SIZE = 3'd0;
    localparam cfg_index_t REG_CLIP_MIN = 3'd1;
    localparam cfg_index_t REG_CLIP_MAX = 3'd2;
    localparam cfg_index_t REG_SOURCE_ORIGIN = 3'd3;
    localparam cfg_index_t REG_DEST_ORIGIN = 3'd4;
    localparam cfg_index_t REG_BLIT_SIZE = 3'd5;
    localparam cfg_index_t REG_MASK_COLOR = 3'd6;
    localparam cfg_index_t REG_FINAL_COLOR_MODE = 3'd7;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_COPY = 2'd0;
    localparam mode_t MODE_KEYED = 2'd1;
    localparam mode_t MODE_RECOLOR = 2'd2;
    localparam mode_t MODE_RECOLOR_ALT = 2'd3;

    function automatic coord_t sext16(input logic [15:0] v);
        return XW'($signed(v));
    endfunction

endpackage

// ===== hdl/clipped_color_key_blit.sv =====
// ----------------------------------------------------------------------------
// clipped_color_key_blit
// Per-pixel blitter with source window, clip rectangle and color key.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one source pixel request (column, row, color) per cycle,
//   held off while s_ready is low. m_* returns exactly one result per
//   request, in order: write enable, linear destination address and color;
//   a rejected pixel gives all zeros. cfg_* writes the eight control
//   registers, is always ready and is to be written only while no request
//   is in flight; the block does not enforce this. Three register stages:
//   window and key compare, clip and bounds compare with the row multiply,
//   then the address add. Throughput is one request per cycle while the
//   output is not stalled, with a single width multiplier in the pipeline.
// Reset clears every control register and empties the pipeline.
// When the receiver stalls, each stage holds its request and empty stages
// keep filling; s_ready drops only when all three stages hold a request.
// ----------------------------------------------------------------------------
module clipped_color_key_blit #(
    parameter int MAX_DIM = 4096,
    parameter int COLOR_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  ccb_pkg::cfg_index_t    cfg_index,
    input  ccb_pkg::cfg_data_t     cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [11:0]            s_source_x,
    input  logic [11:0]            s_source_y,
    input  logic [23:0]            s_source_color,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_write_enable,
    output logic [23:0]            m_dest_address,
    output logic [23:0]            m_write_color
);
    import ccb_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;
    localparam int PW = 2 * DW;
    localparam int AW = (PW + 1 > COLOR_W) ? PW + 1 : COLOR_W;

    // control registers
    logic [31:0] dest_size_reg;
    logic [31:0] clip_min_reg;
    logic [31:0] clip_max_reg;
    logic [31:0] source_origin_reg;
    logic [31:0] dest_origin_reg;
    logic [31:0] blit_size_reg;
    logic [23:0] mask_color_reg;
    logic [25:0] final_color_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_size_reg <= '0;
            clip_min_reg <= '0;
            clip_max_reg <= '0;
            source_origin_reg <= '0;
            dest_origin_reg <= '0;
            blit_size_reg <= '0;
            mask_color_reg <= '0;
            final_color_mode_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEST_SIZE:        dest_size_reg <= cfg_data;
                REG_CLIP_MIN:         clip_min_reg <= cfg_data;
                REG_CLIP_MAX:         clip_max_reg <= cfg_data;
                REG_SOURCE_ORIGIN:    source_origin_reg <= cfg_data;
                REG_DEST_ORIGIN:      dest_origin_reg <= cfg_data;
                REG_BLIT_SIZE:        blit_size_reg <= cfg_data;
                REG_MASK_COLOR:       mask_color_reg <= cfg_data[23:0];
                REG_FINAL_COLOR_MODE: final_color_mode_reg <= cfg_data[25:0];
                default: ;
            endcase
        end
    end

    // decoded control values
    coord_t sox, soy, bw, bh, dox, doy;
    coord_t cminx, cminy, cmaxx, cmaxy;
    logic [DW-1:0] w_sat, h_sat;
    mode_t mode;
    logic key_en, recolor;

    assign sox = sext16(source_origin_reg[15:0]);
    assign soy = sext16(source_origin_reg[31:16]);
    assign bw = sext16(blit_size_reg[15:0]);
    assign bh = sext16(blit_size_reg[31:16]);
    assign dox = sext16(dest_origin_reg[15:0]);
    assign doy = sext16(dest_origin_reg[31:16]);
    assign cminx = sext16(clip_min_reg[15:0]);
    assign cminy = sext16(clip_min_reg[31:16]);
    assign cmaxx = sext16(clip_max_reg[15:0]);
    assign cmaxy = sext16(clip_max_reg[31:16]);
    assign mode = final_color_mode_reg[25:24];

    always_comb begin
        if (dest_size_reg[15:0] > 16'(MAX_DIM)) begin
            w_sat = DW'(MAX_DIM);
        end else begin
            w_sat = DW'(dest_size_reg[15:0]);
        end
        if (dest_size_reg[31:16] > 16'(MAX_DIM)) begin
            h_sat = DW'(MAX_DIM);
        end else begin
            h_sat = DW'(dest_size_reg[31:16]);
        end
    end

    always_comb begin
        case (mode) inside
            MODE_COPY: begin
                key_en = 1'b0;
                recolor = 1'b0;
            end
            MODE_KEYED: begin
                key_en = 1'b1;
                recolor = 1'b0;
            end
            MODE_RECOLOR, MODE_RECOLOR_ALT: begin
                key_en = 1'b1;
                recolor = 1'b1;
            end
            default: begin
                key_en = 1'b0;
                recolor = 1'b0;
            end
        endcase
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || m_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: source window, destination coordinates, color key
    coord_t sx, sy;
    logic win1_next, win1_reg;
    logic key1_next, key1_reg;
    coord_t dx1_next, dx1_reg, dy1_next, dy1_reg;
    logic [23:0] color1_next, color1_reg;

    assign sx = $signed(XW'(s_source_x));
    assign sy = $signed(XW'(s_source_y));

    always_comb begin
        win1_next = (sx >= sox) && (sx <= sox + bw - $signed(XW'(1)))
                 && (sy >= soy) && (sy <= soy + bh - $signed(XW'(1)));
        dx1_next = sx + dox - sox;
        dy1_next = sy + doy - soy;
        key1_next = key_en && (s_source_color[CW-1:0] == mask_color_reg[CW-1:0]);
        if (recolor) begin
            color1_next = 24'(final_color_mode_reg[CW-1:0]);
        end else begin
            color1_next = 24'(s_source_color[CW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            win1_reg <= win1_next;
            key1_reg <= key1_next;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            color1_reg <= color1_next;
        end
    end

    // stage 2: clip and image bounds, row times width
    logic ok2_next, ok2_reg;
    logic [PW-1:0] prod2_next, prod2_reg;
    logic [DW-1:0] dx2_reg;
    logic [23:0] color2_reg;

    always_comb begin
        ok2_next = win1_reg && !key1_reg
                && (dx1_reg >= cminx) && (dx1_reg <= cmaxx)
                && (dy1_reg >= cminy) && (dy1_reg <= cmaxy)
                && (dx1_reg >= $signed(XW'(0))) && (dx1_reg < $signed(XW'(w_sat)))
                && (dy1_reg >= $signed(XW'(0))) && (dy1_reg < $signed(XW'(h_sat)));
        prod2_next = {{DW{1'b0}}, dy1_reg[DW-1:0]} * {{DW{1'b0}}, w_sat};
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            ok2_reg <= ok2_next;
            prod2_reg <= prod2_next;
            dx2_reg <= dx1_reg[DW-1:0];
            color2_reg <= color1_reg;
        end
    end

    // stage 3: address add and result register
    logic [AW-1:0] addr_sum;
    logic we3_reg;
    logic [23:0] addr3_reg, color3_reg;

    assign addr_sum = AW'(prod2_reg) + AW'(dx2_reg);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            we3_reg <= ok2_reg;
            addr3_reg <= ok2_reg ? addr_sum[23:0] : 24'd0;
            color3_reg <= ok2_reg ? color2_reg : 24'd0;
        end
    end

    assign m_write_enable = we3_reg;
    assign m_dest_address = addr3_reg;
    assign m_write_color = color3_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_dest_address == 24'd0 && m_write_color == 24'd0)
        else $error("rejected pixel carries nonzero payload");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && !m_ready)
        else $error("input stalled with an empty stage");

    a_key_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_enable && mode == MODE_KEYED
        |-> m_write_color[CW-1:0] != mask_color_reg[CW-1:0])
        else $error("key color written in keyed copy");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !m_ready |=> v3_reg && $stable(addr3_reg) && $stable(we3_reg))
        else $error("stalled result changed");
`endif

endmodule
